/* src/ntpl_pkg.sv */
// Shared constants, types and the elaboration-time daylight saving table
// for the NTP to local time converter. No dependencies.
`default_nettype none

package ntpl_pkg;

   localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
   localparam int SecsPerHour = 3600;
   localparam int SecsPerDay  = 86400;
   localparam int EdgeSecs    = 2 * SecsPerHour;
   localparam int WeekDays    = 7;
   localparam int March       = 3;
   localparam int MarchDay    = 7;
   localparam int October     = 10;
   localparam int OctoberDay  = 31;
   localparam int FirstYear   = 1968;

   // Local standard time is split into buckets of 2**25 seconds (about 388 days),
   // so a bucket spans at most two calendar years plus a few days of January of
   // a third year, where no daylight saving window lies.
   localparam int BucketShift = 25;
   localparam int BucketBits  = 6;
   localparam int BucketCount = 64;

   localparam logic signed [16:0] ZONE_STEP = 17'sd3600;

   typedef struct packed {
      logic signed [31:0] begin_a;
      logic signed [31:0] end_a;
      logic signed [31:0] begin_b;
      logic signed [31:0] end_b;
   } dst_row_type;

   typedef dst_row_type [BucketCount-1:0] dst_table_type;

   function automatic longint days_from_civil(longint y, longint m, longint d);
      longint yy;
      longint era;
      longint yoe;
      longint mm;
      longint doy;
      longint doe;
      yy  = (m <= 2) ? y - 1 : y;
      era = yy / 400;
      yoe = yy - era * 400;
      mm  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mm + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // First Sunday strictly after the given day; day zero was a Thursday.
   function automatic longint sunday_after(longint days);
      longint wd;
      wd = (days + 4) % WeekDays;
      if (wd < 0) begin
         wd = wd + WeekDays;
      end
      return days + WeekDays - wd;
   endfunction

   function automatic longint window_begin(longint y);
      return sunday_after(days_from_civil(y, March, MarchDay)) * SecsPerDay + EdgeSecs;
   endfunction

   function automatic longint window_end(longint y);
      return sunday_after(days_from_civil(y, October, OctoberDay)) * SecsPerDay + EdgeSecs;
   endfunction

   // For every bucket, the daylight saving windows of the year that holds the
   // bucket's first second and of the year after it.
   function automatic dst_table_type build_dst_table();
      dst_table_type tbl;
      longint        start_sec;
      longint        y;
      for (int b = 0; b < BucketCount; b++) begin
         start_sec = longint'(b - 1) * (longint'(1) << BucketShift);
         y = FirstYear;
         while (days_from_civil(y + 1, 1, 1) * SecsPerDay <= start_sec) begin
            y = y + 1;
         end
         tbl[b].begin_a = 32'(window_begin(y));
         tbl[b].end_a   = 32'(window_end(y));
         tbl[b].begin_b = 32'(window_begin(y + 1));
         tbl[b].end_b   = 32'(window_end(y + 1));
      end
      return tbl;
   endfunction

   localparam dst_table_type DstTable = build_dst_table();

endpackage

`default_nettype wire

/* src/ntpl_dst_window.sv */
// Daylight saving window check on local standard time.
// Depends on ntpl_pkg for the per-bucket window table.
`default_nettype none

module ntpl_dst_window (
   input  wire logic signed [31:0] local_std_seconds,
   output logic signed [31:0]      local_seconds,
   output logic                    dst_active
);
   import ntpl_pkg::*;

   logic [BucketBits-1:0] bucket;
   dst_row_type           row;
   logic                  in_a;
   logic                  in_b;

   // The arithmetic shift spans -1..62, so adding one maps it onto 0..63.
   assign bucket = local_std_seconds[BucketShift+BucketBits-1:BucketShift]
                   + BucketBits'(1);
   assign row = DstTable[bucket];

   // Each window lies inside its own year, so at most one of these can be true.
   assign in_a = (local_std_seconds >= row.begin_a) && (local_std_seconds < row.end_a);
   assign in_b = (local_std_seconds >= row.begin_b) && (local_std_seconds < row.end_b);

   assign dst_active    = in_a || in_b;
   assign local_seconds = dst_active ? local_std_seconds + 32'sd3600 : local_std_seconds;

endmodule

`default_nettype wire

/* src/ntp_to_local_time_us_dst.sv */
// Top level: NTP seconds to US local time with daylight saving flag.
// Depends on ntpl_pkg and ntpl_dst_window.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_ntp_seconds
//   rsp      out        rsp_valid/rsp_stall   rsp_local_seconds, rsp_dst_active
//   csr      in         csr_wr_en             csr_wr_data (zone offset in hours)
//
// Two register stages: the request register holds local standard time, the
// response register holds the result. One request is taken every cycle
// while no stalled response backs up into the request stage. A stalled
// response holds while the request stage can still take one more request.
// Reset is synchronous and clears the valid flags and the zone offset.
`default_nettype none

module ntp_to_local_time_us_dst (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [4:0]         csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_ntp_seconds,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_local_seconds,
   output logic                    rsp_dst_active
);
   import ntpl_pkg::*;

   logic signed [4:0]  zone_ff;
   logic signed [4:0]  zone_in;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic signed [31:0] s1_local_ff;
   logic signed [31:0] s1_local_in;
   logic               s2_valid_ff;
   logic               s2_valid_in;
   logic signed [31:0] s2_local_ff;
   logic               s2_dst_ff;

   logic               s2_take;
   logic               s1_free;
   logic               req_accept;
   logic [31:0]        unix_seconds;
   logic signed [16:0] zone_seconds;
   logic signed [31:0] win_local;
   logic               win_dst;

   assign s2_take    = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign s1_free    = !s1_valid_ff || s2_take;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && s1_free;

   assign zone_in     = csr_wr_en ? $signed(csr_wr_data) : zone_ff;
   assign s1_valid_in = s1_free ? req_valid : 1'b1;
   assign s2_valid_in = s2_take || (s2_valid_ff && rsp_stall);

   // Timestamps before 1970 saturate to Unix second zero.
   assign unix_seconds = (req_ntp_seconds >= NTP_UNIX_DELTA) ?
                         req_ntp_seconds - NTP_UNIX_DELTA : 32'd0;
   assign zone_seconds = 17'(zone_ff * ZONE_STEP);
   assign s1_local_in  = $signed(unix_seconds) + 32'(zone_seconds);

   ntpl_dst_window u_dst_window (
      .local_std_seconds (s1_local_ff),
      .local_seconds     (win_local),
      .dst_active        (win_dst)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         zone_ff     <= zone_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_local_ff <= s1_local_in;
      end
      if (s2_take) begin
         s2_local_ff <= win_local;
         s2_dst_ff   <= win_dst;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_local_seconds = s2_local_ff;
   assign rsp_dst_active    = s2_dst_ff;

endmodule

`default_nettype wire

/* test/ntp_to_local_time_us_dst_test.sv */
// Self-checking testbench for ntp_to_local_time_us_dst: random and directed NTP
// timestamps under several zone offsets, checked against a built-in US DST predictor.
// Depends on ntpl_pkg and the converter RTL.

module ntp_to_local_time_us_dst_test;

   import ntpl_pkg::*;

   typedef struct {
      logic signed [31:0] local_seconds;
      logic               dst_active;
   } local_time_type;

   class local_time_model;
      logic signed [4:0] zone_hours;
      local_time_type    pending_times[$];
      int                mismatches;

      function new();
         zone_hours = 5'sd0;
         mismatches = 0;
      endfunction

      static function longint floor_div(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && ((a < 0) != (b < 0))) begin
            q--;
         end
         return q;
      endfunction

      // Days since 1970-01-01 to proleptic Gregorian year, March-based eras.
      static function longint civil_year(longint days);
         longint z;
         longint era;
         longint doe;
         longint yoe;
         longint doy;
         longint mp;
         longint y;
         z   = days + 719468;
         era = floor_div(z, 146097);
         doe = z - era * 146097;
         yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp  = (5 * doy + 2) / 153;
         y   = yoe + era * 400;
         if (mp >= 10) begin
            y++;
         end
         return y;
      endfunction

      static function longint civil_day(longint y, longint m, longint d);
         longint yy;
         longint era;
         longint yoe;
         longint doy;
         longint doe;
         yy  = (m <= 2) ? y - 1 : y;
         era = floor_div(yy, 400);
         yoe = yy - era * 400;
         doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         return era * 146097 + doe - 719468;
      endfunction

      // The day after which the Sunday is searched is never itself returned.
      static function longint next_sunday(longint days);
         longint wd;
         wd = days + 4 - floor_div(days + 4, WeekDays) * WeekDays;
         return days + WeekDays - wd;
      endfunction

      static function longint window_open(longint y);
         return next_sunday(civil_day(y, March, MarchDay)) * SecsPerDay + EdgeSecs;
      endfunction

      static function longint window_close(longint y);
         return next_sunday(civil_day(y, October, OctoberDay)) * SecsPerDay + EdgeSecs;
      endfunction

      function local_time_type convert(logic [31:0] ntp);
         local_time_type res;
         longint         unix_s;
         longint         std_s;
         longint         y;
         logic           in_dst;
         unix_s = (ntp >= NTP_UNIX_DELTA) ? longint'(ntp) - longint'(NTP_UNIX_DELTA) : 0;
         std_s  = unix_s + longint'(zone_hours) * SecsPerHour;
         y      = civil_year(floor_div(std_s, SecsPerDay));
         in_dst = (std_s >= window_open(y)) && (std_s < window_close(y));
         res.local_seconds = 32'(std_s + (in_dst ? SecsPerHour : 0));
         res.dst_active    = in_dst;
         return res;
      endfunction

      function void take_request(logic [31:0] ntp);
         pending_times.push_back(convert(ntp));
      endfunction

      function void check_response(logic signed [31:0] loc_s, logic dst);
         local_time_type want;
         if (pending_times.size() == 0) begin
            $error("rsp_local_seconds: no request outstanding, actual %0d", loc_s);
            mismatches++;
         end else begin
            want = pending_times.pop_front();
            if (loc_s !== want.local_seconds) begin
               $error("local_seconds: expected %0d, actual %0d", want.local_seconds, loc_s);
               mismatches++;
            end
            if (dst !== want.dst_active) begin
               $error("dst_active: expected %0d, actual %0d", want.dst_active, dst);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [4:0]         csr_wr_data = 5'd0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_ntp_seconds = 32'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_local_seconds;
   logic               rsp_dst_active;

   int send_idle = 0;
   int recv_idle = 0;

   local_time_model book = new();

   ntp_to_local_time_us_dst i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ntp_seconds   (req_ntp_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_local_seconds (rsp_local_seconds),
      .rsp_dst_active    (rsp_dst_active)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            book.take_request(req_ntp_seconds);
         end
         if (rsp_valid && !rsp_stall) begin
            book.check_response(rsp_local_seconds, rsp_dst_active);
         end
      end
   end

   function automatic logic [31:0] ntp_for(longint std_s, int zone);
      return 32'(std_s - longint'(zone) * SecsPerHour + longint'(NTP_UNIX_DELTA));
   endfunction

   task automatic set_zone(int zone);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 5'(zone);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.zone_hours = 5'(zone);
   endtask

   task automatic send_request(logic [31:0] ntp);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_ntp_seconds <= ntp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(posedge clock);
      while (book.pending_times.size() != 0) @(posedge clock);
   endtask

   // Mostly timestamps close to DST transitions and New Year, where the
   // calendar logic is most likely to slip.
   function automatic logic [31:0] random_time(int zone);
      longint y;
      longint boundary;
      longint off;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         return $urandom;
      end else if (pick < 45) begin
         return $urandom_range(32'hFFFF_FFFF, NTP_UNIX_DELTA);
      end
      off = ($urandom_range(1)) ? longint'($urandom_range(6)) - 3
                                : longint'($urandom_range(14400)) - 7200;
      if (pick < 85) begin
         y = $urandom_range(2035, 1970);
         boundary = ($urandom_range(1)) ? local_time_model::window_open(y)
                                        : local_time_model::window_close(y);
      end else begin
         y = $urandom_range(2036, 1970);
         boundary = local_time_model::civil_day(y, 1, 1) * SecsPerDay;
      end
      return ntp_for(boundary + off, zone);
   endfunction

   task automatic send_directed(int zone);
      longint yrs[3];
      longint bnd;
      yrs = '{2024, 2000, 2035};
      send_request(32'd0);
      send_request(32'h7FFF_FFFF);
      send_request(NTP_UNIX_DELTA - 32'd1);
      send_request(NTP_UNIX_DELTA);
      send_request(32'h8000_0000);
      send_request(32'hFFFF_FFFF);
      foreach (yrs[k]) begin
         bnd = local_time_model::window_open(yrs[k]);
         send_request(ntp_for(bnd - 1, zone));
         send_request(ntp_for(bnd, zone));
         bnd = local_time_model::window_close(yrs[k]);
         send_request(ntp_for(bnd - 1, zone));
         send_request(ntp_for(bnd, zone));
      end
      bnd = local_time_model::civil_day(2001, 1, 1) * SecsPerDay;
      send_request(ntp_for(bnd - 1, zone));
      send_request(ntp_for(bnd, zone));
   endtask

   initial begin
      int zones[9];
      zones = '{-5, 0, -16, 15, -12, 14, 9, -1, 3};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (zones[p]) begin
         if (p < 3) begin
            send_idle = 32;
            recv_idle = 79;
         end else if (p < 6) begin
            send_idle = 79;
            recv_idle = 32;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         set_zone(zones[p]);
         if (p == 0) begin
            send_directed(zones[p]);
         end
         repeat (106) send_request(random_time(zones[p]));
         req_valid <= 1'b0;
         drain();
      end
      repeat (6) @(posedge clock);
      if (book.mismatches == 0 && book.pending_times.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* ntp_to_local_time_us_dst.f */
src/ntpl_pkg.sv
src/ntpl_dst_window.sv
src/ntp_to_local_time_us_dst.sv
test/ntp_to_local_time_us_dst_test.sv
